@@ hdl/nts_pkg.sv @@
// Package for the note table sequencer: word widths, register indexes,
// table entry types and the note frequency ROM.
// Depends on nothing; every other file uses it.
package nts_pkg;

    localparam int IDX_W   = 6;
    localparam int DUR_W   = 16;
    localparam int NOTE_W  = 6;
    localparam int VEL_W   = 8;
    localparam int FREQ_W  = 12;
    localparam int PRE_W   = 16;
    localparam int BEAT_W  = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LAST_NOTE_INDEX = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESCALE_LIMIT  = 1'd1;

    localparam logic [PRE_W-1:0] PRESCALE_RESET = 16'd200;

    typedef struct packed {
        logic [DUR_W-1:0]  duration;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] index;
        entry_t           entry;
    } tbl_wr_t;

    typedef struct packed {
        logic              action;
        logic [IDX_W-1:0]  entry_index;
        entry_t            entry;
    } in_word_t;

    typedef struct packed {
        logic [FREQ_W-1:0] tone_freq;
        logic [VEL_W-1:0]  velocity;
        logic              gate;
        logic [IDX_W-1:0]  note_position;
        logic              note_started;
    } out_word_t;

    // Equal-tempered frequencies in hertz, C2 up to C7.
    function automatic logic [FREQ_W-1:0] freq_lookup(input logic [NOTE_W-1:0] note);
        logic [FREQ_W-1:0] f;
        case (note)
            6'd0:  f = 12'd65;
            6'd1:  f = 12'd69;
            6'd2:  f = 12'd73;
            6'd3:  f = 12'd78;
            6'd4:  f = 12'd82;
            6'd5:  f = 12'd87;
            6'd6:  f = 12'd92;
            6'd7:  f = 12'd98;
            6'd8:  f = 12'd104;
            6'd9:  f = 12'd110;
            6'd10: f = 12'd117;
            6'd11: f = 12'd123;
            6'd12: f = 12'd130;
            6'd13: f = 12'd139;
            6'd14: f = 12'd147;
            6'd15: f = 12'd156;
            6'd16: f = 12'd165;
            6'd17: f = 12'd175;
            6'd18: f = 12'd185;
            6'd19: f = 12'd196;
            6'd20: f = 12'd208;
            6'd21: f = 12'd220;
            6'd22: f = 12'd233;
            6'd23: f = 12'd246;
            6'd24: f = 12'd262;
            6'd25: f = 12'd277;
            6'd26: f = 12'd294;
            6'd27: f = 12'd311;
            6'd28: f = 12'd330;
            6'd29: f = 12'd349;
            6'd30: f = 12'd370;
            6'd31: f = 12'd392;
            6'd32: f = 12'd415;
            6'd33: f = 12'd440;
            6'd34: f = 12'd466;
            6'd35: f = 12'd493;
            6'd36: f = 12'd523;
            6'd37: f = 12'd554;
            6'd38: f = 12'd587;
            6'd39: f = 12'd622;
            6'd40: f = 12'd659;
            6'd41: f = 12'd698;
            6'd42: f = 12'd740;
            6'd43: f = 12'd784;
            6'd44: f = 12'd831;
            6'd45: f = 12'd880;
            6'd46: f = 12'd932;
            6'd47: f = 12'd988;
            6'd48: f = 12'd1046;
            6'd49: f = 12'd1109;
            6'd50: f = 12'd1175;
            6'd51: f = 12'd1245;
            6'd52: f = 12'd1319;
            6'd53: f = 12'd1397;
            6'd54: f = 12'd1480;
            6'd55: f = 12'd1568;
            6'd56: f = 12'd1661;
            6'd57: f = 12'd1760;
            6'd58: f = 12'd1865;
            6'd59: f = 12'd1976;
            6'd60: f = 12'd2093;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

@@ hdl/nts_if.sv @@
// Valid/ready channel interfaces for the input and result words.
// Depends on nts_pkg for the field widths.
interface nts_in_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [nts_pkg::IDX_W-1:0]    entry_index;
    logic [nts_pkg::DUR_W-1:0]    entry_duration;
    logic [nts_pkg::NOTE_W-1:0]   entry_note;
    logic [nts_pkg::VEL_W-1:0]    entry_velocity;

    modport source (output valid, action, entry_index, entry_duration, entry_note,
                    entry_velocity, input ready);
    modport sink   (input valid, action, entry_index, entry_duration, entry_note,
                    entry_velocity, output ready);
endinterface

interface nts_out_if;
    logic                         valid;
    logic                         ready;
    logic [nts_pkg::FREQ_W-1:0]   tone_freq;
    logic [nts_pkg::VEL_W-1:0]    velocity;
    logic                         gate;
    logic [nts_pkg::IDX_W-1:0]    note_position;
    logic                         note_started;

    modport source (output valid, tone_freq, velocity, gate, note_position,
                    note_started, input ready);
    modport sink   (input valid, tone_freq, velocity, gate, note_position,
                    note_started, output ready);
endinterface

@@ hdl/nts_table.sv @@
// Note table memory: one write port, one registered read port, with
// write-to-read forwarding for a write and read of the same slot in one cycle.
// Depends on nts_pkg.
module nts_table #(
    parameter int NOTE_DEPTH = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  nts_pkg::tbl_wr_t            wr,
    input  logic [nts_pkg::IDX_W-1:0]   rd_index,
    output nts_pkg::entry_t             rd_entry
);
    import nts_pkg::*;

    localparam int AW = $clog2(NOTE_DEPTH);

    entry_t              mem [NOTE_DEPTH];
    entry_t              rdata_reg;
    entry_t              fwd_data_reg;
    logic                fwd_reg;
    logic                rd_ok_reg;
    logic [IDX_W+AW-1:0] wr_ext;
    logic [IDX_W+AW-1:0] rd_ext;
    logic [AW-1:0]       waddr;
    logic [AW-1:0]       raddr;
    logic                wr_ok;
    logic                rd_ok;

    assign wr_ext = {{AW{1'b0}}, wr.index};
    assign rd_ext = {{AW{1'b0}}, rd_index};
    assign waddr  = wr_ext[AW-1:0];
    assign raddr  = rd_ext[AW-1:0];
    assign wr_ok  = 32'(wr.index) < 32'(NOTE_DEPTH);
    assign rd_ok  = 32'(rd_index) < 32'(NOTE_DEPTH);

    always_ff @(posedge clk)
    begin
        if (wr.en && wr_ok)
        begin
            mem[waddr] <= wr.entry;
        end
        rdata_reg    <= mem[raddr];
        fwd_data_reg <= wr.entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg   <= 1'b0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            fwd_reg   <= wr.en && wr_ok && (waddr == raddr);
            rd_ok_reg <= rd_ok;
        end
    end

    // A slot beyond the table reads as all zero.
    assign rd_entry = !rd_ok_reg ? '0 : (fwd_reg ? fwd_data_reg : rdata_reg);

endmodule

@@ hdl/note_table_sequencer_top.sv @@
// Note table sequencer top level: input stage, sequencer update, result register.
// Depends on nts_pkg, nts_if and nts_table.
//
// Usage: words arrive on seq_in. A word with action set stores one entry in the
// note table; a word with action clear is a tick that advances the prescaler,
// the beat counter and the note pointer. Every input word gives exactly one
// result word on seq_out with the held frequency, velocity, gate, the pointer
// and a flag for a note started by that tick.
// Flow: an accepted word is held in the input stage register; when it fires,
// its result is written to the result register, where it waits until seq_out
// takes it.
// Throughput: one word per cycle while seq_out does not stall. The table is read
// every cycle at the pointer that the word in the input stage will see; the read
// of the synchronous table memory and the update of the sequencer counters form a loop through pointer_next.
// Reset: pointer, counters and held outputs clear, the first note is pending,
// last_note_index is 0 and prescale_limit is 200. Table contents are undefined
// until written. Registers are written through cfg_we/cfg_index/cfg_data.
// Stall: a result waits in the output register; one more word can be taken into
// the input stage, after which seq_in.ready stays low until seq_out drains.
module note_table_sequencer_top #(
    parameter int NOTE_DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [nts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nts_pkg::CFG_DATA_W-1:0]    cfg_data,
    nts_in_if.sink                            seq_in,
    nts_out_if.source                         seq_out
);
    import nts_pkg::*;

    // Configuration registers.
    logic [IDX_W-1:0]  last_index_reg;
    logic [PRE_W-1:0]  prescale_limit_reg;

    // Sequencer state.
    logic [PRE_W-1:0]  prescale_count_reg, prescale_count_next;
    logic [BEAT_W-1:0] beat_count_reg, beat_count_next;
    logic              beat_flag_reg, beat_flag_next;
    logic [IDX_W-1:0]  pointer_reg, pointer_next;
    logic [BEAT_W-1:0] elapsed_reg, elapsed_next;
    logic              pending_reg, pending_next;
    logic [FREQ_W-1:0] freq_reg, freq_next;
    logic [VEL_W-1:0]  vel_reg, vel_next;
    logic              gate_reg, gate_next;
    logic              started;

    // Pipeline registers.
    logic              item_valid_reg;
    in_word_t          item_reg;
    logic              out_valid_reg;
    out_word_t         out_reg;

    logic              fire;
    tbl_wr_t           tbl_wr;
    entry_t            cur;

    assign fire         = item_valid_reg && (!out_valid_reg || seq_out.ready);
    assign seq_in.ready = !item_valid_reg || fire;

    assign tbl_wr.en    = fire && item_reg.action;
    assign tbl_wr.index = item_reg.entry_index;
    assign tbl_wr.entry = item_reg.entry;

    // The read address is the pointer after this cycle's update, so the data
    // lines up with the word that enters the update stage next.
    nts_table #(
        .NOTE_DEPTH (NOTE_DEPTH)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (tbl_wr),
        .rd_index (pointer_next),
        .rd_entry (cur)
    );

    always_comb
    begin
        logic              beat_now;
        logic [BEAT_W:0]   limit_sum;
        logic [IDX_W:0]    nxt;

        prescale_count_next = prescale_count_reg;
        beat_count_next     = beat_count_reg;
        beat_flag_next      = beat_flag_reg;
        pointer_next        = pointer_reg;
        elapsed_next        = elapsed_reg;
        pending_next        = pending_reg;
        freq_next           = freq_reg;
        vel_next            = vel_reg;
        gate_next           = gate_reg;
        started             = 1'b0;
        beat_now            = 1'b0;
        limit_sum           = {1'b0, elapsed_reg} + (BEAT_W+1)'(cur.duration);
        nxt                 = {1'b0, pointer_reg} + 1'b1;

        if (fire && !item_reg.action)
        begin
            beat_now = beat_flag_reg;
            if (prescale_count_reg >= prescale_limit_reg)
            begin
                prescale_count_next = '0;
                beat_count_next     = beat_count_reg + 1'b1;
                beat_now            = 1'b1;
            end
            else
            begin
                prescale_count_next = prescale_count_reg + 1'b1;
            end
            beat_flag_next = beat_now;

            if (beat_now)
            begin
                if (pending_reg)
                begin
                    freq_next      = freq_lookup(cur.note);
                    vel_next       = cur.vel;
                    gate_next      = 1'b1;
                    pending_next   = 1'b0;
                    beat_flag_next = 1'b0;
                    started        = 1'b1;
                end
                // The note ends once the beat count passes its end beat.
                if ({1'b0, beat_count_next} > limit_sum)
                begin
                    elapsed_next = limit_sum[BEAT_W-1:0];
                    pointer_next = nxt[IDX_W-1:0];
                    if (nxt > {1'b0, last_index_reg})
                    begin
                        pointer_next    = '0;
                        elapsed_next    = '0;
                        beat_count_next = '0;
                    end
                    gate_next    = 1'b0;
                    pending_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_index_reg     <= '0;
            prescale_limit_reg <= PRESCALE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LAST_NOTE_INDEX: last_index_reg     <= cfg_data[IDX_W-1:0];
                REG_PRESCALE_LIMIT:  prescale_limit_reg <= cfg_data[PRE_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_count_reg <= '0;
            beat_count_reg     <= '0;
            beat_flag_reg      <= 1'b0;
            pointer_reg        <= '0;
            elapsed_reg        <= '0;
            pending_reg        <= 1'b1;
            freq_reg           <= '0;
            vel_reg            <= '0;
            gate_reg           <= 1'b0;
            item_valid_reg     <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            prescale_count_reg <= prescale_count_next;
            beat_count_reg     <= beat_count_next;
            beat_flag_reg      <= beat_flag_next;
            pointer_reg        <= pointer_next;
            elapsed_reg        <= elapsed_next;
            pending_reg        <= pending_next;
            freq_reg           <= freq_next;
            vel_reg            <= vel_next;
            gate_reg           <= gate_next;
            if (seq_in.ready)
            begin
                item_valid_reg <= seq_in.valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (seq_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_in.ready)
        begin
            item_reg.action         <= seq_in.action;
            item_reg.entry_index    <= seq_in.entry_index;
            item_reg.entry.duration <= seq_in.entry_duration;
            item_reg.entry.note     <= seq_in.entry_note;
            item_reg.entry.vel      <= seq_in.entry_velocity;
        end
        if (fire)
        begin
            out_reg.tone_freq     <= freq_next;
            out_reg.velocity      <= vel_next;
            out_reg.gate          <= gate_next;
            out_reg.note_position <= pointer_next;
            out_reg.note_started  <= started;
        end
    end

    assign seq_out.valid         = out_valid_reg;
    assign seq_out.tone_freq     = out_reg.tone_freq;
    assign seq_out.velocity      = out_reg.velocity;
    assign seq_out.gate          = out_reg.gate;
    assign seq_out.note_position = out_reg.note_position;
    assign seq_out.note_started  = out_reg.note_started;

endmodule

@@ hdl/nts_checker.sv @@
// Port-level checker for the note table sequencer, with its bind statement.
// Depends on nts_pkg and the ports of note_table_sequencer_top.
module nts_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [nts_pkg::FREQ_W-1:0]   tone_freq,
    input  logic [nts_pkg::IDX_W-1:0]    note_position
);
    import nts_pkg::*;

    // Words taken in but whose result has not yet been taken.
    logic [2:0] outstanding_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_reg + 3'(in_valid && in_ready)
                               - 3'(out_valid && out_ready);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tone_freq)
                                    && $stable(note_position))
        else $error("result word changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> outstanding_reg != 3'd0)
        else $error("result word without a pending input word");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= 3'd2)
        else $error("more words in flight than pipeline stages");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg == 3'd0 |-> in_ready)
        else $error("input not ready while the block is empty");

endmodule

bind note_table_sequencer_top nts_checker u_nts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (seq_in.valid),
    .in_ready      (seq_in.ready),
    .out_valid     (seq_out.valid),
    .out_ready     (seq_out.ready),
    .tone_freq     (seq_out.tone_freq),
    .note_position (seq_out.note_position)
);
